// File: rtl/core/ttay_pkg.sv
// ----------------------------------------------------------------------------
// ttay_pkg
// Shared constants, types and helpers of the tangent approximator pipeline.
// ----------------------------------------------------------------------------
package ttay_pkg;

    // default number of fraction bits on angle and tangent
    localparam int FRAC_BITS_DEF = 16;

    // pi and pi/2 in unsigned Q.32
    localparam logic [33:0] PI_Q32      = 34'd13493037705;
    localparam logic [32:0] HALF_PI_Q32 = 33'd6746518852;

    // floor(2^65 / pi_q32), reciprocal used for the quotient estimate
    localparam logic [65:0] TWO_POW_65 = 66'd1 << 65;
    localparam logic [31:0] RECIP_Q65  = 32'(TWO_POW_65 / 66'(PI_Q32));

    // taylor coefficients in Q29
    localparam logic [31:0] ONE_Q29 = 32'd536870912;
    localparam logic [31:0] C3_Q29  = 32'd178956971;
    localparam logic [31:0] C5_Q29  = 32'd71582788;
    localparam logic [31:0] C7_Q29  = 32'd28973986;
    localparam logic [31:0] C9_Q29  = 32'd11741092;

    // horner steps after the leading coefficient
    localparam int NUM_STEPS = 4;
    localparam logic [31:0] STEP_COEF [NUM_STEPS] = '{C7_Q29, C5_Q29, C3_Q29, ONE_Q29};

    // reset value of the pole window register
    localparam logic [15:0] POLE_WINDOW_RST = 16'd66;

    // sideband that travels with each item
    typedef struct packed {
        logic vld;
        logic neg;
        logic pole;
    } t_tag;

    // q29 product rounding: add half, drop 29 bits
    function automatic logic [31:0] rnd_q29(input logic [63:0] prod);
        logic [63:0] sum;
        sum = prod + (64'd1 << 28);
        return sum[60:29];
    endfunction

endpackage

// File: rtl/core/tangent_taylor_approximator_core.sv
// ----------------------------------------------------------------------------
// tangent_taylor_approximator_core
// Fixed-point tangent of a Q15.16 angle by a five-term taylor series.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken at a clock edge with start high and busy low. busy is
//   high during reset and the first cycle after it, then stays low, so one
//   angle can enter every cycle.
//   Each item gives one result: o_tangent and o_at_pole are shown for one
//   cycle with o_strobe, in the order the items came in.
//   The receiver cannot hold results off, and the pipeline never stalls:
//   one item per cycle sustained.
//   The pipeline has six stages of range reduction (reciprocal multiply,
//   quotient times pi, remainder and fold), three for the pole check and
//   the square, two per horner step over four steps, two for the final
//   multiply and one output stage for scaling and saturation.
//   i_cfg_we writes i_cfg_wdata to the pole window register. Write only while
//   no item is in flight: the block does not enforce it. Reset sets the
//   window to 66 and drops every in-flight item; no result appears for it.
// ----------------------------------------------------------------------------
module tangent_taylor_approximator_core
    import ttay_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_cfg_we,
    input  logic [15:0]        i_cfg_wdata,
    input  logic signed [31:0] i_angle,
    output logic               o_strobe,
    output logic signed [31:0] o_tangent,
    output logic               o_at_pole
);

    localparam int OSH = 29 - FRAC_BITS;
    localparam logic [33:0] POS_MAX = 34'h07FFFFFFF;
    localparam logic [33:0] NEG_MAX = 34'h080000000;

    logic        r_busy;
    logic [15:0] r_pole_window;
    logic        r_strobe;
    logic [31:0] r_tangent;
    logic        r_at_pole;

    logic [32:0] w_m;
    t_tag        w_rtag;
    logic [31:0] w_acc;
    t_tag        w_ptag;
    logic [33:0] w_mag;
    logic [33:0] w_clip;
    logic [31:0] n_tangent;

    // range reduction
    ttay_reduce #(
        .FRAC_BITS (FRAC_BITS)
    ) u_reduce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (start && !r_busy),
        .i_angle (i_angle),
        .o_m     (w_m),
        .o_tag   (w_rtag)
    );

    // pole check and series
    ttay_poly u_poly (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_m           (w_m),
        .i_tag         (w_rtag),
        .i_pole_window (r_pole_window),
        .o_acc         (w_acc),
        .o_tag         (w_ptag)
    );

    // q29 to output format, rounded half up
    if (OSH > 0) begin : g_shr
        assign w_mag = (34'(w_acc) + (34'd1 << (OSH - 1))) >> OSH;
    end else if (OSH == 0) begin : g_same
        assign w_mag = 34'(w_acc);
    end else begin : g_shl
        assign w_mag = 34'(w_acc) << (-OSH);
    end

    // saturate, apply sign, zero at the pole
    always_comb begin
        if (w_ptag.neg) begin
            w_clip = (w_mag > NEG_MAX) ? NEG_MAX : w_mag;
        end else begin
            w_clip = (w_mag > POS_MAX) ? POS_MAX : w_mag;
        end
        if (w_ptag.pole) begin
            n_tangent = '0;
        end else if (w_ptag.neg) begin
            n_tangent = 32'(34'd0 - w_clip);
        end else begin
            n_tangent = w_clip[31:0];
        end
    end

    // control and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy        <= 1'b1;
            r_pole_window <= POLE_WINDOW_RST;
            r_strobe      <= 1'b0;
        end else begin
            r_busy   <= 1'b0;
            r_strobe <= w_ptag.vld;
            if (i_cfg_we) begin
                r_pole_window <= i_cfg_wdata;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        r_tangent <= n_tangent;
        r_at_pole <= w_ptag.pole;
    end

    assign busy      = r_busy;
    assign o_strobe  = r_strobe;
    assign o_tangent = r_tangent;
    assign o_at_pole = r_at_pole;

    // a pole result carries a zero tangent
    a_pole_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_at_pole) |-> (o_tangent == 32'sd0))
        else $error("pole item with nonzero tangent");

    // a zero window never flags a pole
    a_zero_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (r_pole_window == 16'd0)) |-> !o_at_pole)
        else $error("pole flagged with zero window");

    // reset drops every item in flight
    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe)
        else $error("result strobe right after reset");

endmodule

// File: rtl/core/ttay_reduce.sv
// ----------------------------------------------------------------------------
// ttay_reduce
// Range reduction of the angle modulo pi, six register stages. Gives the
// magnitude of the reduced angle in Q.32 (at most pi/2) and its sign.
// ----------------------------------------------------------------------------
module ttay_reduce
    import ttay_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_vld,
    input  logic signed [31:0] i_angle,
    output logic [32:0]        o_m,
    output t_tag               o_tag
);

    localparam int SH  = 32 - FRAC_BITS;
    localparam int QSH = 65 - SH;
    localparam int QW  = SH - 1;
    localparam logic [35:0] PI_36     = 36'(PI_Q32);
    localparam logic [35:0] TWO_PI_36 = 36'({PI_Q32, 1'b0});

    logic        r1_vld, r2_vld, r3_vld, r4_vld, r5_vld, r6_vld;
    logic        r1_neg, r2_neg, r3_neg, r4_neg, r5_neg, r6_neg;
    logic [31:0] r1_u, r2_u, r3_u;
    logic [63:0] r2_prod;
    logic [35:0] r3_qpi;
    logic [35:0] r4_rem;
    logic [33:0] r5_umod;
    logic [32:0] r6_m;

    logic [31:0] n1_u;
    logic [63:0] n2_prod;
    logic [QW-1:0] n3_q;
    logic [35:0] n3_qpi;
    logic [63:0] n4_xs;
    logic [35:0] n4_rem;
    logic [33:0] n5_umod;
    logic        n6_far;
    logic [32:0] n6_m;
    logic        n6_neg;

    // magnitude of the angle, most negative value gives 2^31
    assign n1_u = i_angle[31] ? (32'd0 - $unsigned(i_angle)) : $unsigned(i_angle);

    // quotient estimate by reciprocal, low or exact by at most one
    assign n2_prod = 64'(r1_u) * 64'(RECIP_Q65);
    assign n3_q    = r2_prod[63:QSH];
    assign n3_qpi  = 36'(36'(n3_q) * PI_36);

    // remainder of the scaled magnitude, only the low bits matter
    assign n4_xs  = 64'(r3_u) << SH;
    assign n4_rem = n4_xs[35:0] - r3_qpi;

    // final correction of the remainder
    assign n5_umod = (r4_rem >= PI_36) ? 34'(r4_rem - PI_36) : 34'(r4_rem);

    // fold into [-pi/2, pi/2) and split off the sign
    assign n6_far = r5_umod > 34'(HALF_PI_Q32);
    assign n6_m   = n6_far ? 33'(PI_Q32 - r5_umod) : 33'(r5_umod);
    assign n6_neg = (r5_neg && (r5_umod != '0)) ^ n6_far;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
            r6_vld <= 1'b0;
        end else begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
            r6_vld <= r5_vld;
        end
    end

    // data path
    always_ff @(posedge i_clk) begin
        r1_u    <= n1_u;
        r1_neg  <= i_angle[31];
        r2_u    <= r1_u;
        r2_neg  <= r1_neg;
        r2_prod <= n2_prod;
        r3_u    <= r2_u;
        r3_neg  <= r2_neg;
        r3_qpi  <= n3_qpi;
        r4_neg  <= r3_neg;
        r4_rem  <= n4_rem;
        r5_neg  <= r4_neg;
        r5_umod <= n5_umod;
        r6_neg  <= n6_neg;
        r6_m    <= n6_m;
    end

    assign o_m   = r6_m;
    assign o_tag = '{vld: r6_vld, neg: r6_neg, pole: 1'b0};

    // reciprocal estimate leaves at most one pi too much
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r4_vld |-> (r4_rem < TWO_PI_36))
        else $error("remainder estimate out of range");

    // corrected remainder below pi
    a_umod_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r5_vld |-> (r5_umod < 34'(PI_Q32)))
        else $error("reduced angle not below pi");

    // folded magnitude never above pi/2
    a_mag_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r6_vld |-> (r6_m <= HALF_PI_Q32))
        else $error("folded magnitude above pi/2");

endmodule

// File: rtl/core/ttay_hstep.sv
// ----------------------------------------------------------------------------
// ttay_hstep
// One horner step in Q29: multiply by y, then round and add the coefficient.
// Two register stages, y and the magnitude ride along.
// ----------------------------------------------------------------------------
module ttay_hstep
    import ttay_pkg::*;
#(
    parameter logic [31:0] COEF = ONE_Q29
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [31:0] i_acc,
    input  logic [31:0] i_y,
    input  logic [29:0] i_m29,
    input  t_tag        i_tag,
    output logic [31:0] o_acc,
    output logic [31:0] o_y,
    output logic [29:0] o_m29,
    output t_tag        o_tag
);

    logic [63:0] r_prod;
    logic [31:0] r_y_a, r_y_b;
    logic [29:0] r_m29_a, r_m29_b;
    logic [31:0] r_acc;
    t_tag        r_tag_a, r_tag_b;

    logic [63:0] n_prod;
    logic [31:0] n_acc;

    assign n_prod = 64'(i_acc) * 64'(i_y);
    assign n_acc  = COEF + rnd_q29(r_prod);

    // sideband
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_a <= '0;
            r_tag_b <= '0;
        end else begin
            r_tag_a <= i_tag;
            r_tag_b <= r_tag_a;
        end
    end

    // multiply stage, then round and add stage
    always_ff @(posedge i_clk) begin
        r_prod  <= n_prod;
        r_y_a   <= i_y;
        r_m29_a <= i_m29;
        r_acc   <= n_acc;
        r_y_b   <= r_y_a;
        r_m29_b <= r_m29_a;
    end

    assign o_acc = r_acc;
    assign o_y   = r_y_b;
    assign o_m29 = r_m29_b;
    assign o_tag = r_tag_b;

endmodule

// File: rtl/core/ttay_poly.sv
// ----------------------------------------------------------------------------
// ttay_poly
// Pole check and the five-term odd taylor polynomial on the reduced
// magnitude, evaluated by horner's rule over a chain of step stages.
// ----------------------------------------------------------------------------
module ttay_poly
    import ttay_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [32:0] i_m,
    input  t_tag        i_tag,
    input  logic [15:0] i_pole_window,
    output logic [31:0] o_acc,
    output t_tag        o_tag
);

    logic [32:0] r7_dist;
    logic [29:0] r7_m29, r8_m29, r9_m29;
    logic [59:0] r8_ysq;
    logic [31:0] r9_y;
    t_tag        r7_tag, r8_tag, r9_tag, r10_tag, r11_tag;
    logic [61:0] r10_prod;
    logic [31:0] r11_acc;

    logic [33:0] n7_mr;
    logic        n8_pole;
    logic [59:0] n8_ysq;
    logic [63:0] n10_prod;

    logic [31:0] w_acc [NUM_STEPS+1];
    logic [31:0] w_y   [NUM_STEPS+1];
    logic [29:0] w_m29 [NUM_STEPS+1];
    t_tag        w_tag [NUM_STEPS+1];

    // distance to pi/2 and magnitude rounded to q29
    assign n7_mr = 34'(i_m) + 34'd4;

    // pole window compare and square of the magnitude
    assign n8_pole = r7_dist < {1'b0, i_pole_window, 16'b0};
    assign n8_ysq  = 60'(60'(r7_m29) * 60'(r7_m29));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_tag <= '0;
            r8_tag <= '0;
            r9_tag <= '0;
        end else begin
            r7_tag <= i_tag;
            r8_tag <= '{vld: r7_tag.vld, neg: r7_tag.neg, pole: n8_pole};
            r9_tag <= r8_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r7_dist <= HALF_PI_Q32 - i_m;
        r7_m29  <= n7_mr[32:3];
        r8_ysq  <= n8_ysq;
        r8_m29  <= r7_m29;
        r9_y    <= rnd_q29(64'(r8_ysq));
        r9_m29  <= r8_m29;
    end

    // horner chain, starting from the highest coefficient
    assign w_acc[0] = C9_Q29;
    assign w_y[0]   = r9_y;
    assign w_m29[0] = r9_m29;
    assign w_tag[0] = r9_tag;

    for (genvar g = 0; g < NUM_STEPS; g++) begin : g_step
        ttay_hstep #(
            .COEF (STEP_COEF[g])
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_acc   (w_acc[g]),
            .i_y     (w_y[g]),
            .i_m29   (w_m29[g]),
            .i_tag   (w_tag[g]),
            .o_acc   (w_acc[g+1]),
            .o_y     (w_y[g+1]),
            .o_m29   (w_m29[g+1]),
            .o_tag   (w_tag[g+1])
        );
    end

    // final multiply by the magnitude and rounding
    assign n10_prod = 64'(w_acc[NUM_STEPS]) * 64'(w_m29[NUM_STEPS]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r10_tag <= '0;
            r11_tag <= '0;
        end else begin
            r10_tag <= w_tag[NUM_STEPS];
            r11_tag <= r10_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r10_prod <= n10_prod[61:0];
        r11_acc  <= rnd_q29(64'(r10_prod));
    end

    assign o_acc = r11_acc;
    assign o_tag = r11_tag;

endmodule

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the taylor series tangent core. Angles go in as
// commands with random gaps. Each strobed result is checked field by field
// against a bit-exact fixed-point prediction. The pole window register is
// swept through its reset value, zero, its maximum and random settings.
// ----------------------------------------------------------------------------
module tb;
    import ttay_pkg::*;

    // expected result of one item
    typedef struct packed {
        logic signed [31:0] tangent;
        logic               at_pole;
    } t_tan_res;

    localparam int ANGLE_SHIFT = 32 - FRAC_BITS_DEF;
    localparam int OUT_SHIFT   = 29 - FRAC_BITS_DEF;
    // nominal angle of pi/2 in the input format
    localparam int HALF_PI_Q16 = 102944;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               start       = 1'b0;
    logic               i_cfg_we    = 1'b0;
    logic [15:0]        i_cfg_wdata = '0;
    logic signed [31:0] i_angle     = '0;
    logic               busy;
    logic               o_strobe;
    logic signed [31:0] o_tangent;
    logic               o_at_pole;

    t_tan_res    tan_expected_q[$];
    logic [15:0] pole_window_q = POLE_WINDOW_RST;
    bit          failed        = 1'b0;

    tangent_taylor_approximator_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_angle     (i_angle),
        .o_strobe    (o_strobe),
        .o_tangent   (o_tangent),
        .o_at_pole   (o_at_pole)
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("tb NOT OK");
        $finish;
    end

    // q29 product rounded half up
    function automatic longint unsigned q29_mul(input longint unsigned a,
                                                input longint unsigned b);
        return (a * b + (64'd1 << 28)) >> 29;
    endfunction

    // bit-exact tangent of one angle under a given pole window
    function automatic t_tan_res predict_tangent(input logic signed [31:0] ang,
                                                 input logic [15:0] win);
        longint          x;
        longint          r;
        longint          pi_l;
        longint unsigned m;
        longint unsigned pole_dist;
        longint unsigned m29;
        longint unsigned y;
        longint unsigned acc;
        longint unsigned mag;
        logic            neg;
        t_tan_res        res;
        pi_l = longint'(PI_Q32);
        // reduce modulo pi into [-pi/2, pi/2) in Q.32
        x = longint'(ang) * (longint'(1) << ANGLE_SHIFT);
        r = x % pi_l;
        if (r < 0) r = r + pi_l;
        if (2 * r >= pi_l) r = r - pi_l;
        neg = (r < 0);
        m = neg ? 64'(-r) : 64'(r);
        // distance to pi/2 against the window
        pole_dist = (m > 64'(HALF_PI_Q32)) ? m - 64'(HALF_PI_Q32)
                                           : 64'(HALF_PI_Q32) - m;
        if (pole_dist < (64'(win) << 16)) begin
            res.tangent = '0;
            res.at_pole = 1'b1;
            return res;
        end
        // horner evaluation in q29 on m^2
        m29 = (m + 64'd4) >> 3;
        y   = q29_mul(m29, m29);
        acc = 64'(C9_Q29);
        acc = 64'(C7_Q29) + q29_mul(acc, y);
        acc = 64'(C5_Q29) + q29_mul(acc, y);
        acc = 64'(C3_Q29) + q29_mul(acc, y);
        acc = 64'(ONE_Q29) + q29_mul(acc, y);
        acc = q29_mul(acc, m29);
        mag = (acc + (64'd1 << (OUT_SHIFT - 1))) >> OUT_SHIFT;
        // sign and saturate
        if (neg) begin
            if (mag > 64'h8000_0000) mag = 64'h8000_0000;
            res.tangent = 32'(64'd0 - mag);
        end else begin
            if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
            res.tangent = 32'(mag);
        end
        res.at_pole = 1'b0;
        return res;
    endfunction

    // record accepted items, track the window and check strobed results
    always @(posedge i_clk) begin
        t_tan_res exp_res;
        if (!i_rst_n) begin
            pole_window_q <= POLE_WINDOW_RST;
        end else begin
            if (o_strobe) begin
                if (tan_expected_q.size() == 0) begin
                    $error("result with no item pending: tangent %0d at_pole %0b",
                           o_tangent, o_at_pole);
                    failed = 1'b1;
                end else begin
                    exp_res = tan_expected_q.pop_front();
                    if (o_tangent !== exp_res.tangent) begin
                        $error("tangent: expected %0d, actual %0d",
                               exp_res.tangent, o_tangent);
                        failed = 1'b1;
                    end
                    if (o_at_pole !== exp_res.at_pole) begin
                        $error("at_pole: expected %0b, actual %0b",
                               exp_res.at_pole, o_at_pole);
                        failed = 1'b1;
                    end
                end
            end
            if (start && !busy)
                tan_expected_q.push_back(predict_tangent(i_angle, pole_window_q));
            if (i_cfg_we)
                pole_window_q <= i_cfg_wdata;
        end
    end

    // mostly back to back, some short gaps, a few long ones
    function automatic int gap_cycles();
        int p;
        p = $urandom_range(0, 99);
        if (p < 60) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // send one item after an optional gap; returns at the accepting edge
    task automatic send_angle(input logic signed [31:0] ang, input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start   <= 1'b1;
        i_angle <= ang;
        do @(posedge i_clk); while (busy);
    endtask

    // stop sending and wait until every pending result has come back
    task automatic drain_results();
        start <= 1'b0;
        @(negedge i_clk);
        while (tan_expected_q.size() != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic write_window(input logic [15:0] win);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= win;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    // angle near k*pi + pi/2, within the window plus a margin
    function automatic logic signed [31:0] near_pole_angle(input logic [15:0] win);
        longint k;
        longint center;
        int     span;
        int     offs;
        k      = longint'($urandom_range(0, 1200)) - 600;
        center = (k * longint'(PI_Q32) + longint'(HALF_PI_Q32)) >>> ANGLE_SHIFT;
        span   = int'(win) + 16;
        offs   = int'($urandom_range(0, 2 * span)) - span;
        return 32'(center + offs);
    endfunction

    // field extremes, pole edges and ordinary angles at the reset window
    task automatic test_directed_reset_window();
        logic signed [31:0] angles[$];
        angles = '{32'sd0, 32'sd1, -32'sd1, 32'sh7FFF_FFFF, 32'sh8000_0000,
                   32'(HALF_PI_Q16), -32'(HALF_PI_Q16),
                   32'(HALF_PI_Q16 - 65), 32'(HALF_PI_Q16 - 66),
                   32'(HALF_PI_Q16 - 67), 32'(HALF_PI_Q16 - 80),
                   32'(HALF_PI_Q16 + 67), 32'sd205887, -32'sd205887,
                   32'sd32768, -32'sd32768, 32'sd65536, -32'sd65536,
                   32'sd100000, -32'sd100000, 32'sd51472, 32'sd308831};
        foreach (angles[i]) send_angle(angles[i], (i % 4 == 3) ? 2 : 0);
        drain_results();
    endtask

    // a zero window never flags a pole, even right at pi/2
    task automatic test_zero_window();
        logic signed [31:0] angles[$];
        write_window(16'd0);
        angles = '{32'(HALF_PI_Q16), -32'(HALF_PI_Q16), 32'(HALF_PI_Q16 - 1),
                   32'sd308831, 32'sd0};
        foreach (angles[i]) send_angle(angles[i], 0);
        drain_results();
    endtask

    // random angles under one window setting
    task automatic test_random_window(input logic [15:0] win, input int count);
        logic signed [31:0] ang;
        int                 kind;
        write_window(win);
        for (int i = 0; i < count; i++) begin
            kind = $urandom_range(0, 9);
            if (kind < 4)
                ang = $urandom;
            else if (kind < 7)
                ang = 32'($urandom_range(0, 393216)) - 32'sd196608;
            else
                ang = near_pole_angle(win);
            // every other stretch of 30 items runs back to back
            send_angle(ang, ((i / 30) % 2 == 1) ? 0 : gap_cycles());
        end
        drain_results();
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_reset_window();
        test_zero_window();
        test_random_window(16'hFFFF, 120);
        test_random_window(16'd0, 120);
        test_random_window(POLE_WINDOW_RST, 130);
        test_random_window(16'($urandom_range(1, 65535)), 120);
        test_random_window(16'($urandom_range(1, 300)), 130);

        // catch any stray strobe after the last result
        repeat (40) @(posedge i_clk);
        if (!failed)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
